// ----- design/utf8d_pkg.sv -----
// Shared types, widths and helpers for the UTF-8 decoder with source positions.
// No dependencies; used by utf8_decode_with_position_top.
package utf8d_pkg;

	localparam int unsigned POS_BITS  = 31;
	localparam int unsigned CP_BITS   = 21;
	localparam int unsigned BC_BITS   = 3;
	localparam int unsigned MAX_RES   = 4;
	localparam int unsigned CNT_BITS  = $clog2(MAX_RES + 1);
	localparam int unsigned OUT_BITS  = CP_BITS + BC_BITS + 3 * POS_BITS;
	localparam int unsigned TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [CP_BITS-1:0]  CP_NEWLINE = CP_BITS'(8'h0A);

	// One pending result: code point, bytes consumed and fallback flag.
	typedef struct packed {
		logic [CP_BITS-1:0] cp;
		logic [BC_BITS-1:0] bc;
		logic               bad;
	} res_t;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? POS_MAX : v + POS_BITS'(1);
	endfunction

endpackage

// ----- design/utf8_decode_with_position_top.sv -----
// Top level of the UTF-8 decoder with line, column and code-point positions.
// Depends on utf8d_pkg for result types, widths and the saturating increment.
//
// Usage: source bytes enter on the s_ channel, one byte per beat, with s_tlast
// marking the final byte of the source. Decoded code points leave on the m_
// channel, one per beat, each with its byte count, its zero-based line, column
// and code-point index, and a malformed flag on m_tuser. m_tlast marks the
// last result caused by one input byte; a byte that only extends a pending
// sequence causes no result at all.
// A byte's results are registered in the buffer, then in the output register.
// A byte yields zero to four results (a rejected sequence flushes its lead
// and held bytes one by one), and the output side drains one result per cycle
// from a four-entry result buffer while the receiver is ready. Valid text
// therefore runs at one byte per cycle when the receiver keeps up; s_tready
// drops while more than one result waits, or while one waits and cannot move.
// When the receiver stalls, the output register holds its beat and the buffer
// keeps the remaining results; decoding state is untouched until a new byte
// is accepted. Reset clears the decoder state, all three position counters,
// the buffer and the output valid flag; no clearing pass is needed.
module utf8_decode_with_position_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] source_byte
	input  logic                            s_tlast,  // end_of_source
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// char_code [20:0], byte_count [23:21], line_number [54:24],
	// column_number [85:55], char_index [116:86], zero fill above
	output logic [utf8d_pkg::TDATA_BITS-1:0] m_tdata,
	output logic                            m_tuser,  // malformed
	output logic                            m_tlast   // last_of_run
);

	// Decoder state: pending lead byte, needed and held continuation counts.
	logic [7:0] lead_q;
	logic [1:0] exp_q;
	logic [1:0] held_q;
	// Only the first two continuation bytes of a four-byte sequence are ever
	// held; the last one completes the sequence directly from the input.
	logic [5:0] store_q [2];

	// Result buffer between decode and output register.
	utf8d_pkg::res_t                   slots_s1 [utf8d_pkg::MAX_RES];
	logic [utf8d_pkg::CNT_BITS-1:0]    pend_s1;

	// Position counters.
	logic [utf8d_pkg::POS_BITS-1:0] line_q, col_q, idx_q;

	// Output register.
	logic                            out_valid_q;
	utf8d_pkg::res_t                 out_res_s2;
	logic                            out_last_s2;
	logic [utf8d_pkg::POS_BITS-1:0]  out_line_s2, out_col_s2, out_idx_s2;

	logic accept, pop;

	assign pop      = (pend_s1 != '0) && (!out_valid_q || m_tready);
	assign s_tready = (pend_s1 == '0) ||
		((pend_s1 == utf8d_pkg::CNT_BITS'(1)) && pop);
	assign accept   = s_tvalid && s_tready;

	// ---------------------------------------------------------------
	// Decode of the incoming byte against the pending sequence.
	// ---------------------------------------------------------------
	logic [7:0]                      b;
	logic                            eos;
	logic                            is_cont;
	logic                            do_flush, do_fresh;
	logic [7:0]                      nxt_lead;
	logic [1:0]                      nxt_exp, nxt_held;
	logic                            st_we;
	utf8d_pkg::res_t                 slots_d [utf8d_pkg::MAX_RES];
	logic [utf8d_pkg::CNT_BITS-1:0]  cnt_d;
	logic [utf8d_pkg::CP_BITS-1:0]   seq_cp;
	logic                            seq_ok;
	logic [1:0]                      need;

	assign b       = s_tdata;
	assign eos     = s_tlast;
	assign is_cont = (b[7:6] == 2'b10);

	// Code point and validity of a sequence completed by this byte.
	always_comb begin
		seq_cp = '0;
		seq_ok = 1'b0;
		unique case (exp_q)
			2'd1: begin
				seq_cp = utf8d_pkg::CP_BITS'({lead_q[4:0], b[5:0]});
				seq_ok = (seq_cp >= utf8d_pkg::CP_BITS'(12'h080));
			end
			2'd2: begin
				seq_cp = utf8d_pkg::CP_BITS'({lead_q[3:0], store_q[0], b[5:0]});
				seq_ok = (seq_cp >= utf8d_pkg::CP_BITS'(16'h0800)) &&
					((seq_cp < utf8d_pkg::CP_BITS'(16'hD800)) ||
					 (seq_cp > utf8d_pkg::CP_BITS'(16'hDFFF)));
			end
			2'd3: begin
				seq_cp = {lead_q[2:0], store_q[0], store_q[1], b[5:0]};
				seq_ok = (seq_cp >= utf8d_pkg::CP_BITS'(20'h10000)) &&
					(seq_cp <= utf8d_pkg::CP_BITS'(21'h10FFFF));
			end
			default: begin
				seq_cp = '0;
				seq_ok = 1'b0;
			end
		endcase
	end

	// Continuations a lead byte asks for; zero means not a lead.
	always_comb begin
		priority if (b[7:5] == 3'b110) need = 2'd1;
		else if (b[7:4] == 4'b1110)    need = 2'd2;
		else if (b[7:3] == 5'b11110)   need = 2'd3;
		else                           need = 2'd0;
	end

	always_comb begin
		nxt_lead = lead_q;
		nxt_exp  = exp_q;
		nxt_held = held_q;
		st_we    = 1'b0;
		do_flush = 1'b0;
		do_fresh = 1'b0;
		cnt_d    = '0;
		for (int i = 0; i < utf8d_pkg::MAX_RES; i++) begin
			slots_d[i] = '0;
		end

		if (exp_q == 2'd0) begin
			do_fresh = 1'b1;
		end else if (is_cont) begin
			if ((3'(held_q) + 3'd1) >= 3'(exp_q)) begin
				if (seq_ok) begin
					slots_d[0] = '{cp: seq_cp, bc: 3'(exp_q) + 3'd1, bad: 1'b0};
					cnt_d      = utf8d_pkg::CNT_BITS'(1);
					nxt_exp    = 2'd0;
					nxt_held   = 2'd0;
				end else begin
					do_flush = 1'b1;
					do_fresh = 1'b1;
				end
			end else if (eos) begin
				do_flush = 1'b1;
				do_fresh = 1'b1;
			end else begin
				st_we    = 1'b1;
				nxt_held = held_q + 2'd1;
			end
		end else begin
			do_flush = 1'b1;
			do_fresh = 1'b1;
		end

		// A rejected sequence gives back its lead and held bytes as they came.
		if (do_flush) begin
			slots_d[0] = '{cp: utf8d_pkg::CP_BITS'(lead_q), bc: 3'd1, bad: 1'b1};
			slots_d[1] = '{cp: utf8d_pkg::CP_BITS'({2'b10, store_q[0]}),
				bc: 3'd1, bad: 1'b1};
			slots_d[2] = '{cp: utf8d_pkg::CP_BITS'({2'b10, store_q[1]}),
				bc: 3'd1, bad: 1'b1};
			cnt_d    = utf8d_pkg::CNT_BITS'(held_q) + utf8d_pkg::CNT_BITS'(1);
			nxt_exp  = 2'd0;
			nxt_held = 2'd0;
		end

		// Start afresh at the current byte.
		if (do_fresh) begin
			if (!b[7]) begin
				slots_d[cnt_d[1:0]] = '{cp: utf8d_pkg::CP_BITS'(b), bc: 3'd1, bad: 1'b0};
				cnt_d = cnt_d + utf8d_pkg::CNT_BITS'(1);
			end else if ((need == 2'd0) || eos) begin
				slots_d[cnt_d[1:0]] = '{cp: utf8d_pkg::CP_BITS'(b), bc: 3'd1, bad: 1'b1};
				cnt_d = cnt_d + utf8d_pkg::CNT_BITS'(1);
			end else begin
				nxt_lead = b;
				nxt_exp  = need;
				nxt_held = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			exp_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			lead_q <= nxt_lead;
			exp_q  <= nxt_exp;
			held_q <= nxt_held;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && st_we) begin
			store_q[held_q[0]] <= b[5:0];
		end
	end

	// ---------------------------------------------------------------
	// Result buffer: loaded by an accepted byte, shifted by each pop.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (accept) begin
			pend_s1 <= cnt_d;
		end else if (pop) begin
			pend_s1 <= pend_s1 - utf8d_pkg::CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < utf8d_pkg::MAX_RES; i++) begin
				slots_s1[i] <= slots_d[i];
			end
		end else if (pop) begin
			for (int i = 0; i < utf8d_pkg::MAX_RES - 1; i++) begin
				slots_s1[i] <= slots_s1[i+1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Position counters and output register.
	// ---------------------------------------------------------------
	logic is_nl;
	assign is_nl = (slots_s1[0].cp == utf8d_pkg::CP_NEWLINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				idx_q       <= utf8d_pkg::sat_inc(idx_q);
				if (is_nl) begin
					line_q <= utf8d_pkg::sat_inc(line_q);
					col_q  <= '0;
				end else begin
					col_q  <= utf8d_pkg::sat_inc(col_q);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_s2  <= slots_s1[0];
			out_last_s2 <= (pend_s1 == utf8d_pkg::CNT_BITS'(1));
			out_line_s2 <= line_q;
			out_col_s2  <= col_q;
			out_idx_s2  <= idx_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = utf8d_pkg::TDATA_BITS'({out_idx_s2, out_col_s2, out_line_s2,
		out_res_s2.bc, out_res_s2.cp});
	assign m_tuser  = out_res_s2.bad;
	assign m_tlast  = out_last_s2;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 > utf8d_pkg::CNT_BITS'(1)) |-> !s_tready)
		else $error("input accepted while several results still wait");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 <= utf8d_pkg::CNT_BITS'(utf8d_pkg::MAX_RES))
		else $error("result buffer count beyond its depth");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != 2'd0) |-> (held_q < exp_q))
		else $error("held continuation count reached the needed count");

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[23:21] == 3'd1))
		else $error("malformed result with a byte count other than one");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == utf8d_pkg::sat_inc($past(idx_q))))
		else $error("code-point index did not advance with a result");

endmodule

// ----- verif/utf8_decode_checker.sv -----
// Scoreboard for the UTF-8 decoder: watches both stream channels, predicts each
// decoded code point with its line, column and index, and compares beat by beat.
// Depends on utf8d_pkg for the field widths of the result channel.
module utf8_decode_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] source_byte
	input  logic                            s_tlast,  // end_of_source
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// char_code, byte_count, line_number, column_number, char_index
	input  logic [utf8d_pkg::TDATA_BITS-1:0] m_tdata,
	input  logic                            m_tuser,  // malformed
	input  logic                            m_tlast,  // last_of_run
	output int                              pending,
	output int                              fail_count
);

	localparam int unsigned CP_BITS  = utf8d_pkg::CP_BITS;
	localparam int unsigned BC_BITS  = utf8d_pkg::BC_BITS;
	localparam int unsigned POS_BITS = utf8d_pkg::POS_BITS;

	localparam int BC_LSB   = CP_BITS;
	localparam int LINE_LSB = BC_LSB + BC_BITS;
	localparam int COL_LSB  = LINE_LSB + POS_BITS;
	localparam int IDX_LSB  = COL_LSB + POS_BITS;

	localparam logic [CP_BITS-1:0] NEWLINE_CP = CP_BITS'(8'h0A);
	localparam logic [CP_BITS-1:0] MIN_TWO    = CP_BITS'('h80);
	localparam logic [CP_BITS-1:0] MIN_THREE  = CP_BITS'('h800);
	localparam logic [CP_BITS-1:0] SURR_LO    = CP_BITS'('hD800);
	localparam logic [CP_BITS-1:0] SURR_HI    = CP_BITS'('hDFFF);
	localparam logic [CP_BITS-1:0] MIN_FOUR   = CP_BITS'('h10000);
	localparam logic [CP_BITS-1:0] CP_MAX     = CP_BITS'('h10FFFF);

	typedef struct packed {
		logic [CP_BITS-1:0]  char_code;
		logic [BC_BITS-1:0]  byte_count;
		logic                malformed;
		logic [POS_BITS-1:0] line;
		logic [POS_BITS-1:0] column;
		logic [POS_BITS-1:0] index;
		logic                last_of_run;
	} decoded_cp_t;

	decoded_cp_t         expected_cps[$];
	logic [7:0]          lead;
	logic [5:0]          cont_bits [3];
	int unsigned         cont_needed;
	int unsigned         cont_held;
	logic [POS_BITS-1:0] line_pos;
	logic [POS_BITS-1:0] column_pos;
	logic [POS_BITS-1:0] index_pos;
	int                  mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Queues one code point at the current position and advances the counters.
	function automatic void emit_cp(input logic [CP_BITS-1:0] cp, input int unsigned nbytes,
		input logic bad);
		decoded_cp_t d;
		d.char_code   = cp;
		d.byte_count  = BC_BITS'(nbytes);
		d.malformed   = bad;
		d.line        = line_pos;
		d.column      = column_pos;
		d.index       = index_pos;
		d.last_of_run = 1'b0;
		expected_cps.insert(expected_cps.size(), d);
		if (cp == NEWLINE_CP) begin
			line_pos   = bump(line_pos);
			column_pos = '0;
		end else begin
			column_pos = bump(column_pos);
		end
		index_pos = bump(index_pos);
	endfunction

	// A rejected sequence comes out byte by byte: the lead, then each held byte.
	function automatic void flush_pending();
		emit_cp(CP_BITS'(lead), 1, 1'b1);
		for (int i = 0; i < cont_held; i++)
			emit_cp(CP_BITS'({2'b10, cont_bits[i]}), 1, 1'b1);
		cont_needed = 0;
		cont_held   = 0;
	endfunction

	function automatic void start_fresh(input logic [7:0] b, input logic eos);
		int unsigned needed;
		if (b[7] == 1'b0) begin
			emit_cp(CP_BITS'(b), 1, 1'b0);
			return;
		end
		if (b[7:5] == 3'b110)
			needed = 1;
		else if (b[7:4] == 4'b1110)
			needed = 2;
		else if (b[7:3] == 5'b11110)
			needed = 3;
		else
			needed = 0;
		// Stray continuation, invalid lead, or a lead with nothing after it.
		if (needed == 0 || eos) begin
			emit_cp(CP_BITS'(b), 1, 1'b1);
		end else begin
			lead        = b;
			cont_needed = needed;
			cont_held   = 0;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		int unsigned        before_n;
		logic [CP_BITS-1:0] cp;
		logic               ok;
		decoded_cp_t        tail;
		before_n = expected_cps.size();
		if (cont_needed == 0) begin
			start_fresh(b, eos);
		end else if (b[7:6] != 2'b10) begin
			flush_pending();
			start_fresh(b, eos);
		end else if (cont_held + 1 >= cont_needed) begin
			case (cont_needed)
				1: begin
					cp = CP_BITS'({lead[4:0], b[5:0]});
					ok = cp >= MIN_TWO;
				end
				2: begin
					cp = CP_BITS'({lead[3:0], cont_bits[0], b[5:0]});
					ok = cp >= MIN_THREE && (cp < SURR_LO || cp > SURR_HI);
				end
				default: begin
					cp = {lead[2:0], cont_bits[0], cont_bits[1], b[5:0]};
					ok = cp >= MIN_FOUR && cp <= CP_MAX;
				end
			endcase
			if (ok) begin
				emit_cp(cp, cont_needed + 1, 1'b0);
				cont_needed = 0;
				cont_held   = 0;
			end else begin
				flush_pending();
				start_fresh(b, eos);
			end
		end else if (eos) begin
			flush_pending();
			start_fresh(b, eos);
		end else begin
			cont_bits[cont_held] = b[5:0];
			cont_held++;
		end
		if (expected_cps.size() > before_n) begin
			tail = expected_cps[expected_cps.size() - 1];
			tail.last_of_run = 1'b1;
			expected_cps[expected_cps.size() - 1] = tail;
		end
	endfunction

	function automatic void compare_field(input string what, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, what, want, got);
		end
	endfunction

	function automatic void check_beat();
		decoded_cp_t want;
		if (expected_cps.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected beat, expected none, actual code point 0x%0h",
				$time, m_tdata[CP_BITS-1:0]);
			return;
		end
		want = expected_cps.pop_front();
		compare_field("char_code", want.char_code, m_tdata[BC_LSB-1:0]);
		compare_field("byte_count", want.byte_count, m_tdata[LINE_LSB-1:BC_LSB]);
		compare_field("malformed", want.malformed, m_tuser);
		compare_field("line_number", want.line, m_tdata[COL_LSB-1:LINE_LSB]);
		compare_field("column_number", want.column, m_tdata[IDX_LSB-1:COL_LSB]);
		compare_field("char_index", want.index, m_tdata[IDX_LSB+POS_BITS-1:IDX_LSB]);
		compare_field("last_of_run", want.last_of_run, m_tlast);
	endfunction

	// Results are checked before the byte of the same edge is predicted; the
	// block registers its results, so a byte never answers at its own edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_cps.delete();
			lead        = '0;
			cont_needed = 0;
			cont_held   = 0;
			line_pos    = '0;
			column_pos  = '0;
			index_pos   = '0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			pending <= expected_cps.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// Testbench top for utf8_decode_with_position_top: makes the source byte stream,
// stalls the result channel, and prints the verdict.
// Depends on utf8d_pkg, the decoder RTL and utf8_decode_checker.
module tb;

	// Size of the random part, in accepted source bytes.
	localparam int unsigned RANDOM_BYTES = 120;
	// Long receiver hold-off; far more than the four-entry result buffer can hide.
	localparam int unsigned LONG_HOLD    = 120;
	// Points in the random part where the hold-off and the full drain happen.
	localparam int unsigned HOLD_AT      = 40;
	localparam int unsigned DRAIN_AT     = 100;
	// Quiet cycles after the last result, so late or spurious beats get seen.
	localparam int unsigned SETTLE       = 8;

	// How the receiver drives m_tready during one stretch of cycles.
	typedef enum int unsigned {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_RARELY,
		READY_EVERY_THIRD
	} ready_style_e;

	// Shapes of the random source text. The first four are well-formed but for
	// surrogates drawn by SEQ_THREE; the rest break sequences in ways it rejects.
	typedef enum int unsigned {
		SEQ_ASCII,
		SEQ_TWO,
		SEQ_THREE,
		SEQ_FOUR,
		SEQ_ANY_BYTE,
		SEQ_CUT,
		SEQ_BAD_CONT,
		SEQ_OVERLONG,
		SEQ_OUT_OF_RANGE
	} seq_kind_e;

	// Every input of the block holds a known value from time zero.
	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic [7:0]                       s_tdata  = 8'h00;
	logic                             s_tlast  = 1'b0;
	logic                             m_tready = 1'b0;
	logic                             s_tready;
	logic                             m_tvalid;
	logic [utf8d_pkg::TDATA_BITS-1:0] m_tdata;
	logic                             m_tuser;
	logic                             m_tlast;

	// Raised once by the stimulus; the receiver starts its hold-off on seeing it.
	logic                  hold_request = 1'b0;

	int                    pending;
	int                    fail_count;
	int unsigned           burst_left     = 0;
	int unsigned           bytes_accepted = 0;

	always #1 clk = ~clk;

	utf8_decode_with_position_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// The checker sees exactly what the block sees and keeps the expectations;
	// it hands back how many results are still owed and how many checks failed.
	utf8_decode_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// Sender pacing. Bytes go out in bursts; between bursts tvalid drops for a
	// random gap. A zero gap merges two bursts, and the occasional long burst
	// gives stretches where the sender never idles. Within a burst tvalid stays
	// high across beats, so it is never lowered and raised in the same step.
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
	endtask

	// Offers one source byte, waits for the edge where it was taken, then paces. The
	// ready sampled right after the edge is the value the block had at it.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		bytes_accepted++;
		pace();
	endtask

	// Stops sending and waits until every predicted result has been seen.
	// The checker updates its count through a register, so the value read lags its queue.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [20:0] valid_cp(input int unsigned len);
		case (len)
			2:       return 21'($urandom_range('h80, 'h7FF));
			3:       return 21'($urandom_range('h800, 'hFFFF));
			default: return 21'($urandom_range('h10000, 'h10FFFF));
		endcase
	endfunction

	// Encodes cp in len bytes whatever its value, so overlong and out-of-range
	// forms come out too. Only the first keep bytes are sent, and the byte at
	// corrupt_at (if below keep) is replaced by a random one. Any byte may
	// carry the end-of-source flag, which also cuts sequences short.
	task automatic send_encoded(input logic [20:0] cp, input int unsigned len,
		input int unsigned keep, input int unsigned corrupt_at);
		logic [7:0] seq [4];
		case (len)
			1: seq[0] = {1'b0, cp[6:0]};
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			send_byte((i == corrupt_at) ? 8'($urandom) : seq[i], $urandom_range(0, 19) == 0);
	endtask

	// One random piece of source text. Most of it is well-formed so that the
	// decoder gets through to its multi-byte paths; the rest is noise and
	// broken sequences.
	task automatic send_random_item();
		seq_kind_e   kind;
		int unsigned roll;
		int unsigned len;
		logic [20:0] cp;
		roll = $urandom_range(0, 99);
		if (roll < 28)
			kind = SEQ_ASCII;
		else if (roll < 46)
			kind = SEQ_TWO;
		else if (roll < 61)
			kind = SEQ_THREE;
		else if (roll < 75)
			kind = SEQ_FOUR;
		else
			kind = seq_kind_e'($urandom_range(SEQ_ANY_BYTE, SEQ_OUT_OF_RANGE));
		len = $urandom_range(2, 4);
		case (kind)
			SEQ_ASCII: begin
				// Newlines are frequent enough to move the line counter a lot.
				cp = ($urandom_range(0, 7) == 0) ? 21'h0A : 21'($urandom_range(0, 127));
				send_encoded(cp, 1, 1, 4);
			end
			SEQ_TWO:   send_encoded(valid_cp(2), 2, 2, 4);
			SEQ_THREE: send_encoded(valid_cp(3), 3, 3, 4);
			SEQ_FOUR:  send_encoded(valid_cp(4), 4, 4, 4);
			SEQ_ANY_BYTE: begin
				send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end
			SEQ_CUT: begin
				// The next item breaks in on the pending sequence.
				send_encoded(valid_cp(len), len, $urandom_range(1, len - 1), 4);
			end
			SEQ_BAD_CONT: begin
				send_encoded(valid_cp(len), len, len, $urandom_range(1, len - 1));
			end
			SEQ_OVERLONG: begin
				case (len)
					2:       cp = 21'($urandom_range(0, 'h7F));
					3:       cp = 21'($urandom_range(0, 'h7FF));
					default: cp = 21'($urandom_range(0, 'hFFFF));
				endcase
				send_encoded(cp, len, len, 4);
			end
			default: begin
				// Surrogate halves, or four-byte forms above the last code point.
				if ($urandom_range(0, 1) == 0)
					send_encoded(21'($urandom_range('hD800, 'hDFFF)), 3, 3, 4);
				else
					send_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, 4);
			end
		endcase
	endtask

	// Receiver. It changes its stall style after each random stretch, and once,
	// when asked, holds m_tready low through its long hold-off while the sender
	// keeps offering bytes, so the result buffer fills and s_tready drops.
	initial begin : receiver
		ready_style_e style;
		int unsigned  style_left;
		int unsigned  tick;
		logic         hold_taken;
		style      = READY_ALWAYS;
		style_left = 0;
		tick       = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				m_tready   <= 1'b0;
				hold_taken  = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (style_left == 0) begin
				style      = ready_style_e'($urandom_range(READY_ALWAYS, READY_EVERY_THIRD));
				style_left = $urandom_range(16, 64);
			end
			style_left--;
			tick++;
			case (style)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
				READY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
				default:      m_tready <= (tick % 3 == 0);
			endcase
		end
	end

	initial begin : stimulus
		int unsigned random_base;
		logic        hold_issued;
		logic        drain_issued;
		hold_issued  = 1'b0;
		drain_issued = 1'b0;

		// The block clears its control state in reset; there is no clearing pass.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. ASCII extremes and a newline first.
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h0A, 1'b0);
		// Smallest two-byte, largest three-byte and largest four-byte code points.
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF4, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// Overlong two-byte form: lead flushed, then the continuation alone.
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		// Encoded surrogate half.
		send_byte(8'hED, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h80, 1'b0);
		// Just above the last code point; the final byte yields four results.
		send_byte(8'hF4, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		// Invalid lead byte, then a stray continuation byte.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		// Sequence broken by a byte that is not a continuation.
		send_byte(8'hE2, 1'b0);
		send_byte(8'h41, 1'b0);
		// Sequence cut by the end of the source on a continuation byte.
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		// Lead byte that is itself the last of the source.
		send_byte(8'hC3, 1'b1);
		wait_drained();

		// Random part, with one long receiver hold-off and one full drain.
		random_base = bytes_accepted;
		while (bytes_accepted - random_base < RANDOM_BYTES) begin
			if (!hold_issued && bytes_accepted - random_base >= HOLD_AT) begin
				hold_request <= 1'b1;
				hold_issued   = 1'b1;
			end
			if (!drain_issued && bytes_accepted - random_base >= DRAIN_AT) begin
				wait_drained();
				drain_issued = 1'b1;
			end
			send_random_item();
		end

		// Wait out every owed result, then the SETTLE stretch for stray beats.
		// The verdict is taken on the falling edge, clear of the checker's edge.
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Watchdog. Its timeout is far above what a correct run needs, even with every
	// byte at four results and the slowest receiver style.
	initial begin : watchdog
		#400000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
